FILE: src/sbct_pkg.sv
`default_nettype none

package sbct_pkg;

   // Defaults for the top-level parameters.
   localparam int COORD_BITS_DEF     = 16;
   localparam int TIME_FRAC_BITS_DEF = 15;

   // Fixed result field widths.
   localparam int ENTRY_BITS  = 16;
   localparam int NORMAL_BITS = 2;

   // Lanes of the divider bank: entry and exit time for each axis.
   localparam int NUM_AXES  = 2;
   localparam int NUM_LANES = 4;
   localparam int AXIS_X    = 0;
   localparam int AXIS_Y    = 1;
   localparam int LANE_XIN  = 0;
   localparam int LANE_XOUT = 1;
   localparam int LANE_YIN  = 2;
   localparam int LANE_YOUT = 3;

   // Normal codes.
   localparam logic signed [NORMAL_BITS-1:0] NORMAL_POS  = 2'sd1;
   localparam logic signed [NORMAL_BITS-1:0] NORMAL_NEG  = -2'sd1;
   localparam logic signed [NORMAL_BITS-1:0] NORMAL_NONE = 2'sd0;

   // Per-word flags that travel alongside the divider lanes.
   typedef struct packed {
      logic dxin_neg;
      logic dyin_neg;
      logic vx_zero;
      logic vy_zero;
   } side_type;

endpackage

`default_nettype wire

FILE: src/sbct_if.sv
`default_nettype none

interface sbct_req_if #(
   parameter int COORD_BITS = sbct_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] mover_x;
   logic signed [COORD_BITS-1:0] mover_y;
   logic        [COORD_BITS-2:0] mover_w;
   logic        [COORD_BITS-2:0] mover_h;
   logic signed [COORD_BITS-1:0] mover_vx;
   logic signed [COORD_BITS-1:0] mover_vy;
   logic signed [COORD_BITS-1:0] target_x;
   logic signed [COORD_BITS-1:0] target_y;
   logic        [COORD_BITS-2:0] target_w;
   logic        [COORD_BITS-2:0] target_h;

   modport source (
      output valid, mover_x, mover_y, mover_w, mover_h, mover_vx, mover_vy,
             target_x, target_y, target_w, target_h,
      input  ready
   );
   modport sink (
      input  valid, mover_x, mover_y, mover_w, mover_h, mover_vx, mover_vy,
             target_x, target_y, target_w, target_h,
      output ready
   );
endinterface

interface sbct_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic                                       hit;
   logic        [sbct_pkg::ENTRY_BITS-1:0]     entry_time;
   logic signed [sbct_pkg::NORMAL_BITS-1:0]    normal_x;
   logic signed [sbct_pkg::NORMAL_BITS-1:0]    normal_y;

   modport source (
      output valid, hit, entry_time, normal_x, normal_y,
      input  ready
   );
   modport sink (
      input  valid, hit, entry_time, normal_x, normal_y,
      output ready
   );
endinterface

`default_nettype wire

FILE: src/sbct_front.sv
`default_nettype none

module sbct_front #(
   parameter int COORD_BITS     = sbct_pkg::COORD_BITS_DEF,
   parameter int TIME_FRAC_BITS = sbct_pkg::TIME_FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   sbct_req_if.sink                      req_bus,
   output logic                          valid_ff,
   output sbct_pkg::side_type            side_ff,
   output logic [1:0][COORD_BITS-1:0]    den_ff,
   output logic [3:0][COORD_BITS:0]      mag_ff,
   output logic [3:0]                    neg_ff
);
   import sbct_pkg::*;

   localparam int DW = COORD_BITS + 2;
   localparam int MB = COORD_BITS + 1;

   logic signed [DW-1:0]         mlo [NUM_AXES];
   logic signed [DW-1:0]         msz [NUM_AXES];
   logic signed [DW-1:0]         tlo [NUM_AXES];
   logic signed [DW-1:0]         tsz [NUM_AXES];
   logic signed [COORD_BITS-1:0] vel [NUM_AXES];
   logic signed [DW-1:0]         din [NUM_AXES];
   logic signed [DW-1:0]         dout [NUM_AXES];
   logic signed [DW-1:0]         ndin [NUM_AXES];
   logic signed [DW-1:0]         ndout [NUM_AXES];
   logic signed [COORD_BITS-1:0] nvel [NUM_AXES];
   logic                         vpos [NUM_AXES];
   logic                         vzero [NUM_AXES];
   logic [1:0][COORD_BITS-1:0]   den_in;
   logic [3:0][MB-1:0]           mag_in;
   logic [3:0]                   neg_in;
   side_type                     side_in;

   assign mlo[AXIS_X] = DW'(req_bus.mover_x);
   assign mlo[AXIS_Y] = DW'(req_bus.mover_y);
   assign msz[AXIS_X] = signed'(DW'(req_bus.mover_w));
   assign msz[AXIS_Y] = signed'(DW'(req_bus.mover_h));
   assign tlo[AXIS_X] = DW'(req_bus.target_x);
   assign tlo[AXIS_Y] = DW'(req_bus.target_y);
   assign tsz[AXIS_X] = signed'(DW'(req_bus.target_w));
   assign tsz[AXIS_Y] = signed'(DW'(req_bus.target_h));
   assign vel[AXIS_X] = req_bus.mover_vx;
   assign vel[AXIS_Y] = req_bus.mover_vy;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         vzero[a] = (vel[a] == '0);
         vpos[a]  = !vel[a][COORD_BITS-1] && !vzero[a];
         if (vpos[a]) begin
            din[a]  = tlo[a] - (mlo[a] + msz[a]);
            dout[a] = (tlo[a] + tsz[a]) - mlo[a];
         end else begin
            din[a]  = (tlo[a] + tsz[a]) - mlo[a];
            dout[a] = tlo[a] - (mlo[a] + msz[a]);
         end
         ndin[a]  = -din[a];
         ndout[a] = -dout[a];
         nvel[a]  = -vel[a];
         den_in[a] = vel[a][COORD_BITS-1] ? unsigned'(nvel[a]) : unsigned'(vel[a]);
         mag_in[2*a]   = din[a][DW-1]  ? MB'(ndin[a])  : MB'(din[a]);
         mag_in[2*a+1] = dout[a][DW-1] ? MB'(ndout[a]) : MB'(dout[a]);
         neg_in[2*a]   = din[a][DW-1]  ^ vel[a][COORD_BITS-1];
         neg_in[2*a+1] = dout[a][DW-1] ^ vel[a][COORD_BITS-1];
      end
      side_in.dxin_neg = din[AXIS_X][DW-1];
      side_in.dyin_neg = din[AXIS_Y][DW-1];
      side_in.vx_zero  = vzero[AXIS_X];
      side_in.vy_zero  = vzero[AXIS_Y];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         den_ff  <= den_in;
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/sbct_div_step.sv
`default_nettype none

module sbct_div_step #(
   parameter int COORD_BITS     = sbct_pkg::COORD_BITS_DEF,
   parameter int TIME_FRAC_BITS = sbct_pkg::TIME_FRAC_BITS_DEF,
   parameter int STEP           = 0
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   en,
   input  wire logic                                   in_valid,
   input  wire sbct_pkg::side_type                     in_side,
   input  wire logic [1:0][COORD_BITS-1:0]             in_den,
   input  wire logic [3:0][COORD_BITS:0]               in_mag,
   input  wire logic [3:0]                             in_neg,
   input  wire logic [3:0][COORD_BITS-1:0]             in_rem,
   input  wire logic [3:0][COORD_BITS+TIME_FRAC_BITS:0] in_q,
   output logic                                        valid_ff,
   output sbct_pkg::side_type                          side_ff,
   output logic [1:0][COORD_BITS-1:0]                  den_ff,
   output logic [3:0][COORD_BITS:0]                    mag_ff,
   output logic [3:0]                                  neg_ff,
   output logic [3:0][COORD_BITS-1:0]                  rem_ff,
   output logic [3:0][COORD_BITS+TIME_FRAC_BITS:0]     q_ff
);
   import sbct_pkg::*;

   localparam int MB     = COORD_BITS + 1;
   localparam int QB     = MB + TIME_FRAC_BITS;
   localparam bit USE_NUM = (STEP < MB);
   localparam int BIT_IX = USE_NUM ? (MB - 1 - STEP) : 0;

   logic [3:0]                  num_bit;
   logic [3:0][COORD_BITS:0]    trial;
   logic [3:0][COORD_BITS:0]    diff;
   logic [3:0]                  ge;
   logic [3:0][COORD_BITS-1:0]  rem_in;
   logic [3:0][QB-1:0]          q_in;

   // One restoring-division step per lane: bring down the next numerator
   // bit, then subtract the divisor if it fits.
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         num_bit[l] = USE_NUM ? in_mag[l][BIT_IX] : 1'b0;
         trial[l]   = {in_rem[l], num_bit[l]};
         diff[l]    = trial[l] - {1'b0, in_den[l/2]};
         ge[l]      = (trial[l] >= {1'b0, in_den[l/2]});
         rem_in[l]  = ge[l] ? diff[l][COORD_BITS-1:0] : trial[l][COORD_BITS-1:0];
         q_in[l]    = {in_q[l][QB-2:0], ge[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= in_side;
         den_ff  <= in_den;
         mag_ff  <= in_mag;
         neg_ff  <= in_neg;
         rem_ff  <= rem_in;
         q_ff    <= q_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/sbct_finish.sv
`default_nettype none

module sbct_finish #(
   parameter int COORD_BITS     = sbct_pkg::COORD_BITS_DEF,
   parameter int TIME_FRAC_BITS = sbct_pkg::TIME_FRAC_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    en,
   input  wire logic                                    in_valid,
   input  wire sbct_pkg::side_type                      in_side,
   input  wire logic [3:0]                              in_neg,
   input  wire logic [3:0][COORD_BITS-1:0]              in_rem,
   input  wire logic [3:0][COORD_BITS+TIME_FRAC_BITS:0] in_q,
   sbct_rsp_if.source                                   rsp_bus
);
   import sbct_pkg::*;

   localparam int QB = COORD_BITS + 1 + TIME_FRAC_BITS;
   localparam int TW = QB + 2;
   localparam logic signed [TW-1:0] POS_INF  = {1'b0, {(TW-1){1'b1}}};
   localparam logic signed [TW-1:0] NEG_INF  = {1'b1, {(TW-1){1'b0}}};
   localparam logic signed [TW-1:0] TIME_ONE = TW'(1) << TIME_FRAC_BITS;

   logic [3:0][TW-1:0]  up;
   logic [3:0][TW-1:0]  t_in;
   logic [3:0][TW-1:0]  t_ff;
   side_type            side_ff;
   logic                valid_ff;

   logic signed [TW-1:0] xin, xout, yin, yout, tin, tout;
   logic                 x_later, hit;
   logic [ENTRY_BITS-1:0]           entry_in;
   logic signed [NORMAL_BITS-1:0]   nx_in, ny_in;

   // Stage A: turn magnitude quotients into floor-rounded signed times.
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         up[l]   = TW'(in_q[l]) + TW'(in_rem[l] != '0);
         t_in[l] = in_neg[l] ? (TW'(0) - up[l]) : TW'(in_q[l]);
      end
      if (in_side.vx_zero) begin
         t_in[LANE_XIN]  = NEG_INF;
         t_in[LANE_XOUT] = POS_INF;
      end
      if (in_side.vy_zero) begin
         t_in[LANE_YIN]  = NEG_INF;
         t_in[LANE_YOUT] = POS_INF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= t_in;
         side_ff <= in_side;
      end
   end

   // Stage B: combine the axes.
   always_comb begin
      xin     = signed'(t_ff[LANE_XIN]);
      xout    = signed'(t_ff[LANE_XOUT]);
      yin     = signed'(t_ff[LANE_YIN]);
      yout    = signed'(t_ff[LANE_YOUT]);
      x_later = (xin > yin);
      tin     = x_later ? xin : yin;
      tout    = (xout < yout) ? xout : yout;
      hit     = !((tin > tout) || (xin[TW-1] && yin[TW-1]) ||
                  (xin > TIME_ONE) || (yin > TIME_ONE));
      nx_in   = NORMAL_NONE;
      ny_in   = NORMAL_NONE;
      if (hit) begin
         entry_in = tin[ENTRY_BITS-1:0];
         if (x_later) begin
            nx_in = side_ff.dxin_neg ? NORMAL_POS : NORMAL_NEG;
         end else begin
            ny_in = side_ff.dyin_neg ? NORMAL_POS : NORMAL_NEG;
         end
      end else begin
         entry_in = TIME_ONE[ENTRY_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_bus.valid <= 1'b0;
      end else if (en) begin
         rsp_bus.valid <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_bus.hit        <= hit;
         rsp_bus.entry_time <= entry_in;
         rsp_bus.normal_x   <= nx_in;
         rsp_bus.normal_y   <= ny_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/swept_box_collision_time.sv
// Swept box collision time.
// A box that moves by (mover_vx, mover_vy) during one frame is tested
// against a box that stands still. Each request word carries both boxes in
// signed Q12.4, sizes in unsigned Q11.4; each response word gives hit,
// the entry time as a fraction of the frame in steps of 2^-TIME_FRAC_BITS
// (1.0 when there is no hit) and the normal of the surface struck.
// Both channels use a valid/ready handshake; a word moves on a rising clock
// edge where both are high. Every request word yields exactly one response
// word, in order.
// The front stage forms the axis distances, a chain of divider steps runs
// the four restoring dividers, each step adding the next quotient bit, a
// finishing stage fixes the rounding, and a last stage combines the axes
// into the output register.
// Throughput is one word per clock. The whole pipeline advances together
// while the output register is empty or being taken; when the receiver
// holds ready low with a word waiting, req_bus.ready drops and every stage
// holds its contents, so nothing is lost or repeated.
// Synchronous reset clears all valid bits; the block then accepts at once.
`default_nettype none

module swept_box_collision_time #(
   parameter int COORD_BITS     = sbct_pkg::COORD_BITS_DEF,
   parameter int TIME_FRAC_BITS = sbct_pkg::TIME_FRAC_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   sbct_req_if.sink    req_bus,
   sbct_rsp_if.source  rsp_bus
);
   import sbct_pkg::*;

   localparam int MB = COORD_BITS + 1;
   localparam int QB = MB + TIME_FRAC_BITS;
   localparam logic [QB+1:0] TIME_ONE_W = (QB+2)'(1) << TIME_FRAC_BITS;
   localparam logic [ENTRY_BITS-1:0] TIME_ONE_E = TIME_ONE_W[ENTRY_BITS-1:0];

   logic en;

   // Divider chain; index 0 is the front stage output.
   logic                       c_valid [0:QB];
   side_type                   c_side  [0:QB];
   logic [1:0][COORD_BITS-1:0] c_den   [0:QB];
   logic [3:0][MB-1:0]         c_mag   [0:QB];
   logic [3:0]                 c_neg   [0:QB];
   logic [3:0][COORD_BITS-1:0] c_rem   [0:QB];
   logic [3:0][QB-1:0]         c_q     [0:QB];

   // The pipeline moves whenever the output slot is free or being emptied.
   assign en            = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = en;

   sbct_front #(
      .COORD_BITS     (COORD_BITS),
      .TIME_FRAC_BITS (TIME_FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .req_bus  (req_bus),
      .valid_ff (c_valid[0]),
      .side_ff  (c_side[0]),
      .den_ff   (c_den[0]),
      .mag_ff   (c_mag[0]),
      .neg_ff   (c_neg[0])
   );

   assign c_rem[0] = '0;
   assign c_q[0]   = '0;

   for (genvar s = 0; s < QB; s++) begin : g_step
      sbct_div_step #(
         .COORD_BITS     (COORD_BITS),
         .TIME_FRAC_BITS (TIME_FRAC_BITS),
         .STEP           (s)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (c_valid[s]),
         .in_side  (c_side[s]),
         .in_den   (c_den[s]),
         .in_mag   (c_mag[s]),
         .in_neg   (c_neg[s]),
         .in_rem   (c_rem[s]),
         .in_q     (c_q[s]),
         .valid_ff (c_valid[s+1]),
         .side_ff  (c_side[s+1]),
         .den_ff   (c_den[s+1]),
         .mag_ff   (c_mag[s+1]),
         .neg_ff   (c_neg[s+1]),
         .rem_ff   (c_rem[s+1]),
         .q_ff     (c_q[s+1])
      );
   end

   sbct_finish #(
      .COORD_BITS     (COORD_BITS),
      .TIME_FRAC_BITS (TIME_FRAC_BITS)
   ) u_finish (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (c_valid[QB]),
      .in_side  (c_side[QB]),
      .in_neg   (c_neg[QB]),
      .in_rem   (c_rem[QB]),
      .in_q     (c_q[QB]),
      .rsp_bus  (rsp_bus)
   );

   // The divisor of the last stage is not needed by the finishing stages;
   // it is still checked to stay with its word below.

   // A miss always reports entry at 1.0 and no normal.
   a_miss_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.hit |->
         rsp_bus.entry_time == TIME_ONE_E &&
         rsp_bus.normal_x == NORMAL_NONE && rsp_bus.normal_y == NORMAL_NONE)
      else $error("miss word carries contact data");

   // A hit has exactly one nonzero normal component.
   a_hit_normal : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.hit |->
         $onehot({rsp_bus.normal_x != NORMAL_NONE, rsp_bus.normal_y != NORMAL_NONE}))
      else $error("hit word without a single normal axis");

   // A held response blocks new requests.
   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request taken while the output is stalled");

   // A stall freezes the last divider stage together with its divisor.
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(c_den[QB]) && $stable(c_valid[QB]))
      else $error("divider stage moved during a stall");

   // Reset empties the output.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response valid after reset");

endmodule

`default_nettype wire

FILE: tb/sv/sbct_checker.sv
module sbct_checker (
   input  wire logic clock,
   input  wire logic reset,
   sbct_req_if.sink  req_mon,
   sbct_rsp_if.sink  rsp_mon,
   output int        fail_count,
   output int        pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import sbct_pkg::*;

   localparam longint FRAC_ONE = 64'sd1 << 15;
   localparam longint TIME_SAT = (64'sd1 << 32) - 1;
   localparam longint NEVER    = 64'sd1 << 62;

   typedef struct packed {
      logic                           hit;
      logic [ENTRY_BITS-1:0]          entry_time;
      logic signed [NORMAL_BITS-1:0]  normal_x;
      logic signed [NORMAL_BITS-1:0]  normal_y;
   } contact_type;

   contact_type contact_queue[$];

   function automatic longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && ((num < 0) != (den < 0))) q = q - 1;
      if (q > TIME_SAT) q = TIME_SAT;
      if (q < -TIME_SAT) q = -TIME_SAT;
      return q;
   endfunction

   // Entry distance and entry/exit times along one axis.
   function automatic void sweep_axis(input longint lo, input longint size,
                                      input longint vel, input longint tlo,
                                      input longint tsize, output longint dist_in,
                                      output longint t_in, output longint t_out);
      longint dout;
      if (vel > 0) begin
         dist_in = tlo - (lo + size);
         dout    = (tlo + tsize) - lo;
      end else begin
         dist_in = (tlo + tsize) - lo;
         dout    = tlo - (lo + size);
      end
      if (vel == 0) begin
         t_in  = -NEVER;
         t_out = NEVER;
      end else begin
         t_in  = floor_quot(dist_in * FRAC_ONE, vel);
         t_out = floor_quot(dout * FRAC_ONE, vel);
      end
   endfunction

   function automatic contact_type predict_contact();
      contact_type c;
      longint dxin, xin, xout, dyin, yin, yout, tin, tout;
      sweep_axis(longint'(req_mon.mover_x), longint'({1'b0, req_mon.mover_w}),
                 longint'(req_mon.mover_vx), longint'(req_mon.target_x),
                 longint'({1'b0, req_mon.target_w}), dxin, xin, xout);
      sweep_axis(longint'(req_mon.mover_y), longint'({1'b0, req_mon.mover_h}),
                 longint'(req_mon.mover_vy), longint'(req_mon.target_y),
                 longint'({1'b0, req_mon.target_h}), dyin, yin, yout);
      tin  = (xin > yin) ? xin : yin;
      tout = (xout < yout) ? xout : yout;
      c.hit = !(tin > tout || (xin < 0 && yin < 0) || xin > FRAC_ONE || yin > FRAC_ONE);
      c.normal_x = NORMAL_NONE;
      c.normal_y = NORMAL_NONE;
      if (c.hit) begin
         if (xin > yin) c.normal_x = (dxin < 0) ? NORMAL_POS : NORMAL_NEG;
         else           c.normal_y = (dyin < 0) ? NORMAL_POS : NORMAL_NEG;
      end else begin
         tin = FRAC_ONE;
      end
      c.entry_time = tin[ENTRY_BITS-1:0];
      return c;
   endfunction

   always @(posedge clock) begin
      contact_type want, got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) contact_queue.push_back(predict_contact());
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.hit, rsp_mon.entry_time, rsp_mon.normal_x, rsp_mon.normal_y};
            if (contact_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected response word %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = contact_queue.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p, got %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending = contact_queue.size();
   end
endmodule

FILE: tb/sv/tb_swept_box_collision_time.sv
module tb_swept_box_collision_time;
   timeunit 1ns;
   timeprecision 1ps;
   import sbct_pkg::*;

   // Pipeline depth with default widths, used for the final drain.
   localparam int LATENCY    = 35;
   localparam int RAND_WORDS = 1400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   bit   calm = 1'b0;       // Set for the last part of the run: no idling at all.
   bit   choke_done = 1'b0;

   sbct_req_if req_bus ();
   sbct_rsp_if rsp_bus ();

   swept_box_collision_time dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   sbct_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus.sink),
      .rsp_mon    (rsp_bus.sink),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard limit far beyond the slowest legal run.
   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // A pair of boxes as one request word.
   typedef struct {
      logic signed [15:0] mx, my, vx, vy, tx, ty;
      logic [14:0]        mw, mh, tw, th;
   } box_pair_type;

   // Sends one word: it stays on the bus until the block takes it. Random
   // idle bursts come before the word unless the run is in its calm part.
   task automatic send_pair(input box_pair_type p);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.mover_x  <= p.mx;
      req_bus.mover_y  <= p.my;
      req_bus.mover_w  <= p.mw;
      req_bus.mover_h  <= p.mh;
      req_bus.mover_vx <= p.vx;
      req_bus.mover_vy <= p.vy;
      req_bus.target_x <= p.tx;
      req_bus.target_y <= p.ty;
      req_bus.target_w <= p.tw;
      req_bus.target_h <= p.th;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   function automatic box_pair_type pair_of(int mx, int my, int mw, int mh, int vx,
                                            int vy, int tx, int ty, int tw, int th);
      box_pair_type p;
      p.mx = 16'(mx); p.my = 16'(my); p.mw = 15'(mw); p.mh = 15'(mh);
      p.vx = 16'(vx); p.vy = 16'(vy);
      p.tx = 16'(tx); p.ty = 16'(ty); p.tw = 15'(tw); p.th = 15'(th);
      return p;
   endfunction

   // Mostly realistic pairs: the target is placed near the mover's path so
   // that hits, misses and both normals all show up; some words are pure noise.
   function automatic box_pair_type random_pair();
      box_pair_type p;
      int span;
      p.mx = 16'($urandom); p.my = 16'($urandom); p.mw = 15'($urandom);
      p.mh = 15'($urandom); p.vx = 16'($urandom); p.vy = 16'($urandom);
      p.tx = 16'($urandom); p.ty = 16'($urandom);
      p.tw = 15'($urandom); p.th = 15'($urandom);
      if ($urandom_range(0, 9) < 8) begin
         span = 1 << $urandom_range(4, 12);
         p.mw = 15'($urandom_range(1, span));
         p.mh = 15'($urandom_range(1, span));
         p.tw = 15'($urandom_range(1, span));
         p.th = 15'($urandom_range(1, span));
         p.mx = 16'($signed($urandom_range(0, 4 * span)) - 2 * span);
         p.my = 16'($signed($urandom_range(0, 4 * span)) - 2 * span);
         p.vx = 16'($signed($urandom_range(0, 8 * span)) - 4 * span);
         p.vy = 16'($signed($urandom_range(0, 8 * span)) - 4 * span);
         p.tx = 16'($signed($urandom_range(0, 4 * span)) - 2 * span);
         p.ty = 16'($signed($urandom_range(0, 4 * span)) - 2 * span);
         case ($urandom_range(0, 5))
            0: p.vx = '0;
            1: p.vy = '0;
            default: ;
         endcase
      end
      return p;
   endfunction

   // Receiver: random stalls, one long hold-off once the sender is busy so
   // the pipeline fills and back-pressures the input, no stalls when calm.
   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!choke_done && pending > 4) begin
            choke_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            for (hold = 0; hold < 3 * LATENCY; hold++) @(negedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin
      int drain;
      req_bus.valid    = 1'b0;
      req_bus.mover_x  = '0; req_bus.mover_y  = '0;
      req_bus.mover_w  = '0; req_bus.mover_h  = '0;
      req_bus.mover_vx = '0; req_bus.mover_vy = '0;
      req_bus.target_x = '0; req_bus.target_y = '0;
      req_bus.target_w = '0; req_bus.target_h = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words: head-on hits on each face, both velocities zero,
      // one velocity zero, already overlapping, misses, and the extreme
      // coordinates, sizes and velocities where the quotients are largest.
      send_pair(pair_of(0, 0, 16, 16, 64, 0, 32, 0, 16, 16));
      send_pair(pair_of(64, 0, 16, 16, -64, 0, 0, 0, 16, 16));
      send_pair(pair_of(0, 0, 16, 16, 0, 64, 0, 32, 16, 16));
      send_pair(pair_of(0, 64, 16, 16, 0, -64, 0, 0, 16, 16));
      send_pair(pair_of(0, 0, 16, 16, 0, 0, 8, 8, 16, 16));
      send_pair(pair_of(0, 0, 16, 16, 0, 0, 500, 500, 16, 16));
      send_pair(pair_of(0, 0, 16, 16, 40, 40, 8, 8, 16, 16));
      send_pair(pair_of(0, 0, 16, 16, 10, 10, 200, 200, 16, 16));
      send_pair(pair_of(0, 0, 16, 16, 40, 40, 32, 32, 16, 16));
      send_pair(pair_of(-32768, -32768, 32767, 32767, 32767, 32767,
                        32767, 32767, 32767, 32767));
      send_pair(pair_of(32767, 32767, 0, 0, -32768, -32768,
                        -32768, -32768, 0, 0));
      send_pair(pair_of(-32768, 32767, 32767, 0, 1, -1, 32767, -32768, 0, 32767));
      send_pair(pair_of(0, 0, 0, 0, 1, 1, 1, 1, 0, 0));
      send_pair(pair_of(0, 0, 0, 0, -1, -1, -1, -1, 0, 0));
      send_pair(pair_of(-1, -1, 32767, 32767, -32768, 32767, -1, -1, 32767, 32767));
      send_pair(pair_of(0, 0, 16, 16, 64, 64, 32, 32, 16, 16));
      send_pair(pair_of(0, 0, 16, 16, 0, 64, 500, 32, 16, 16));

      for (int n = 0; n < RAND_WORDS; n++) begin
         if (n == RAND_WORDS - 200) calm = 1'b1;
         send_pair(random_pair());
      end
      req_bus.valid <= 1'b0;

      drain = 0;
      while (pending != 0 && drain < 100000) begin
         @(negedge clock);
         drain++;
      end
      repeat (2 * LATENCY) @(negedge clock);

      if (pending == 0 && fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
